[rtl/drr_pkg.sv]
// ----------------------------------------------------------------------------
// drr_pkg: shared types and constants
// Command kinds, screen limits and the command record queued between the
// front end and the raster engine.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam int MaxWidth  = 128;
  localparam int MaxHeight = 64;
  localparam int MaxRadius = 63;
  localparam int Cells     = MaxWidth * MaxHeight;
  localparam int AddrW     = $clog2(Cells);
  // start points stay below 2^FoldTop in magnitude; one fold per step down to 0
  localparam int FoldTop   = 12;
  localparam int RemW      = FoldTop + 8;

  typedef enum logic [2:0] {
    KIND_READ = 3'd0,
    KIND_PLOT = 3'd1,
    KIND_DISC = 3'd2,
    KIND_RING = 3'd3,
    KIND_BOTH = 3'd4
  } kind_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BLANK  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic [5:0]         radius;
    logic [5:0]         thickness;
    logic [15:0]        char_code;
    logic [15:0]        fill_color;
    logic [15:0]        ring_color;
    logic               skip;
    logic               wrap;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_READ_WAIT,
    ST_SCAN,
    ST_DONE
  } eng_state_t;

endpackage

[rtl/disc_ring_rasterizer.sv]
// ----------------------------------------------------------------------------
// disc_ring_rasterizer: character-cell framebuffer with disc and ring drawing
// Commands enter a two-entry queue and are carried out by the raster engine.
// ----------------------------------------------------------------------------
// channel    group        dir   payload
// command    s_axis_*     in    tuser: kind; tdata: x_pos..wrap (see port)
// result     m_axis_*     out   tdata: read_char, read_attr, cells_written
// config     cfg_*        in    index 0 width, 1 height, 2 blank code
//
// Each command is accepted, then its start point is folded modulo the screen
// step by step; a read or plot then accesses its one cell, a disc or ring
// scans its 2r by 2r box with an extra step for each kind-4 cell in both disc
// and ring, set by the single memory write port; then the result is offered.
// The memory's 8192 cells are cleared after reset; meanwhile no command starts.
// Up to two commands queue while the engine or the result side stalls.
// ----------------------------------------------------------------------------
module disc_ring_rasterizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  // x_pos[11:0], y_pos[23:12], radius[29:24], thickness[35:30],
  // char_code[51:36], fill_color[67:52], ring_color[83:68], skip_blank[84],
  // wrap[85], zero[95:86]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_char[15:0], read_attr[31:16], cells_written[46:32], zero[47]
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [7:0]    screen_width;
  logic [6:0]    screen_height;
  logic [15:0]   blank_code;
  drr_pkg::cmd_t in_cmd, q_cmd;
  logic          q_valid, q_ready;
  logic [46:0]   res_data;

  always_comb begin
    in_cmd.kind       = s_axis_tuser;
    in_cmd.x_pos      = s_axis_tdata[11:0];
    in_cmd.y_pos      = s_axis_tdata[23:12];
    in_cmd.radius     = s_axis_tdata[29:24];
    in_cmd.thickness  = s_axis_tdata[35:30];
    in_cmd.char_code  = s_axis_tdata[51:36];
    in_cmd.fill_color = s_axis_tdata[67:52];
    in_cmd.ring_color = s_axis_tdata[83:68];
    in_cmd.skip       = s_axis_tdata[84];
    in_cmd.wrap       = s_axis_tdata[85];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 8'd80;
      screen_height <= 7'd25;
      blank_code    <= 16'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drr_pkg::CFG_WIDTH:  screen_width  <= cfg_data[7:0];
        drr_pkg::CFG_HEIGHT: screen_height <= cfg_data[6:0];
        drr_pkg::CFG_BLANK:  blank_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  drr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (in_cmd),
    .blank_code (blank_code),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd)
  );

  drr_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res_data      (res_data)
  );

  assign m_axis_tdata = {1'b0, res_data};

endmodule

[rtl/drr_front.sv]
// ----------------------------------------------------------------------------
// drr_front: command intake and queue
// Accepts commands, saturates the radius, folds the skip test into the
// record, and holds up to two records for the engine.
// ----------------------------------------------------------------------------
module drr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  drr_pkg::cmd_t   in_cmd,
  input  logic [15:0]     blank_code,
  output logic            q_valid,
  input  logic            q_ready,
  output drr_pkg::cmd_t   q_cmd
);

  drr_pkg::cmd_t slot [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  drr_pkg::cmd_t cooked;
  logic          push;
  logic          pop;

  always_comb begin
    cooked = in_cmd;
    if (in_cmd.radius > 6'(drr_pkg::MaxRadius)) cooked.radius = 6'(drr_pkg::MaxRadius);
    cooked.skip = in_cmd.skip && (in_cmd.char_code == blank_code);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cooked;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/drr_engine.sv]
// ----------------------------------------------------------------------------
// drr_engine: raster engine and cell memory
// Folds the start point modulo the screen size, scans the disc box one cell
// per cycle (an overlapping cell of kind 4 takes a second step), maps and
// writes cells, reads back a cell, and clears the memory after reset.
// ----------------------------------------------------------------------------
module drr_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  drr_pkg::cmd_t   q_cmd,
  input  logic [7:0]      screen_width,
  input  logic [6:0]      screen_height,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [46:0]     res_data
);

  localparam int AW = drr_pkg::AddrW;
  localparam int RW = drr_pkg::RemW;

  logic [31:0]         mem [drr_pkg::Cells];
  logic [31:0]         rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [31:0]         wr_data;
  logic [AW-1:0]       rd_addr;

  drr_pkg::eng_state_t state, state_next;
  drr_pkg::cmd_t       cmd;
  logic                clearing;
  logic [AW-1:0]       clr_addr;
  logic [6:0]          hcnt, wcnt;
  logic                second;
  logic [14:0]         count;
  logic                rd_ok;
  logic [7:0]          eff_w;
  logic [6:0]          eff_h;
  logic                cell_cmd;
  logic                q_cell;

  // scan point
  logic signed [7:0]   dx, dy;
  logic [12:0]         dsq, outer, inner;
  logic signed [6:0]   rt;
  logic                in_disc, in_ring;
  logic signed [12:0]  px, py;
  logic                map_ok;
  logic [AW-1:0]       map_addr;
  logic [6:0]          last, q_last;
  logic                want1, want2;
  logic                step;

  // start point folding
  logic signed [12:0]  q_sx, q_sy;
  logic [RW-1:0]       rem_x, rem_y, fold_x, fold_y, sub_x, sub_y;
  logic [3:0]          fold_k;
  logic [7:0]          wx;
  logic [6:0]          wy;

  // coordinate mapping for one point
  logic signed [12:0]  mx, my;
  logic [7:0]          xm;
  logic [6:0]          ym;

  always_comb begin
    eff_w = (screen_width == 8'd0) ? 8'd1 :
            (screen_width > 8'(drr_pkg::MaxWidth)) ? 8'(drr_pkg::MaxWidth) : screen_width;
    eff_h = (screen_height == 7'd0) ? 7'd1 :
            (screen_height > 7'(drr_pkg::MaxHeight)) ? 7'(drr_pkg::MaxHeight) : screen_height;
  end

  always_comb begin
    dx    = 8'(signed'({2'b0, cmd.radius})) - 8'(signed'({1'b0, wcnt}));
    dy    = 8'(signed'({2'b0, cmd.radius})) - 8'(signed'({1'b0, hcnt}));
    dsq   = 13'(16'(dx) * 16'(dx)) + 13'(16'(dy) * 16'(dy));
    outer = 13'(cmd.radius) * 13'(cmd.radius);
    rt    = 7'(signed'({1'b0, cmd.radius})) - 7'(signed'({1'b0, cmd.thickness}));
    inner = 13'(14'(rt) * 14'(rt));
    in_disc = dsq < outer;
    in_ring = in_disc && (dsq > inner);
    last  = 7'({cmd.radius, 1'b0} - 7'd1);
    px = 13'(cmd.x_pos) + 13'(last) - 13'(wcnt);
    py = 13'(cmd.y_pos) + 13'(last) - 13'(hcnt);
    if (state == drr_pkg::ST_SCAN) begin
      mx = px;
      my = py;
    end else begin
      mx = 13'(cmd.x_pos);
      my = 13'(cmd.y_pos);
    end
    cell_cmd = (drr_pkg::kind_t'(cmd.kind) == drr_pkg::KIND_READ) ||
               (drr_pkg::kind_t'(cmd.kind) == drr_pkg::KIND_PLOT);
  end

  always_comb begin
    q_cell = (drr_pkg::kind_t'(q_cmd.kind) == drr_pkg::KIND_READ) ||
             (drr_pkg::kind_t'(q_cmd.kind) == drr_pkg::KIND_PLOT);
    q_last = 7'({q_cmd.radius, 1'b0} - 7'd1);
    q_sx   = 13'(q_cmd.x_pos) + (q_cell ? 13'd0 : 13'(q_last));
    q_sy   = 13'(q_cmd.y_pos) + (q_cell ? 13'd0 : 13'(q_last));
    sub_x  = RW'(eff_w) << fold_k;
    sub_y  = RW'(eff_h) << fold_k;
    fold_x = (rem_x >= sub_x) ? rem_x - sub_x : rem_x;
    fold_y = (rem_y >= sub_y) ? rem_y - sub_y : rem_y;
  end

  always_comb begin
    if (cmd.wrap) begin
      xm = wx;
      ym = wy;
      map_ok = 1'b1;
    end else begin
      xm = 8'(mx);
      ym = 7'(my);
      map_ok = (mx >= 0) && (mx < $signed({5'b0, eff_w})) &&
               (my >= 0) && (my < $signed({6'b0, eff_h}));
    end
    map_addr = AW'(ym) * AW'(eff_w) + AW'(xm);
  end

  always_comb begin
    unique case (drr_pkg::kind_t'(cmd.kind))
      drr_pkg::KIND_DISC: begin want1 = in_disc; want2 = 1'b0; end
      drr_pkg::KIND_RING: begin want1 = in_ring; want2 = 1'b0; end
      drr_pkg::KIND_BOTH: begin want1 = in_disc; want2 = in_ring; end
      default:            begin want1 = 1'b0;    want2 = 1'b0; end
    endcase
    step = !(want2 && !second);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      drr_pkg::ST_IDLE:
        if (q_valid && !clearing) begin
          unique case (drr_pkg::kind_t'(q_cmd.kind))
            drr_pkg::KIND_READ: state_next = drr_pkg::ST_PREP;
            drr_pkg::KIND_PLOT: state_next = drr_pkg::ST_PREP;
            drr_pkg::KIND_DISC, drr_pkg::KIND_RING, drr_pkg::KIND_BOTH:
              state_next = (q_cmd.radius == 6'd0 || q_cmd.skip) ? drr_pkg::ST_DONE
                                                                 : drr_pkg::ST_PREP;
            default: state_next = drr_pkg::ST_DONE;
          endcase
        end
      drr_pkg::ST_PREP:
        if (fold_k == 4'd0) state_next = cell_cmd ? drr_pkg::ST_READ : drr_pkg::ST_SCAN;
      drr_pkg::ST_READ:
        state_next = drr_pkg::ST_READ_WAIT;
      drr_pkg::ST_READ_WAIT:
        state_next = drr_pkg::ST_DONE;
      drr_pkg::ST_SCAN:
        if (step && wcnt == last && hcnt == last) state_next = drr_pkg::ST_DONE;
      drr_pkg::ST_DONE:
        if (res_ready) state_next = drr_pkg::ST_IDLE;
      default: state_next = drr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == drr_pkg::ST_IDLE) && !clearing;
    res_valid = (state == drr_pkg::ST_DONE);
    rd_addr   = map_addr;
    wr_en     = 1'b0;
    wr_addr   = map_addr;
    wr_data   = {cmd.fill_color, cmd.char_code};
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = 32'd0;
    end else if (state == drr_pkg::ST_READ && drr_pkg::kind_t'(cmd.kind) == drr_pkg::KIND_PLOT) begin
      wr_en = map_ok && !cmd.skip;
    end else if (state == drr_pkg::ST_SCAN) begin
      wr_en = map_ok && (second ? want2 : want1);
      if (second) wr_data = {cmd.ring_color, cmd.char_code};
    end
    if (drr_pkg::kind_t'(cmd.kind) == drr_pkg::KIND_READ && rd_ok)
      res_data = {count, rd_data};
    else
      res_data = {count, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state == drr_pkg::ST_READ) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == drr_pkg::ST_IDLE && q_valid && !clearing) begin
      cmd    <= q_cmd;
      rem_x  <= RW'(q_sx) + (RW'(eff_w) << drr_pkg::FoldTop);
      rem_y  <= RW'(q_sy) + (RW'(eff_h) << drr_pkg::FoldTop);
      fold_k <= 4'(drr_pkg::FoldTop);
    end
    if (rst) begin
      state    <= drr_pkg::ST_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      hcnt     <= '0;
      wcnt     <= '0;
      second   <= 1'b0;
      count    <= '0;
      rd_ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(drr_pkg::Cells - 1)) clearing <= 1'b0;
      end
      if (state == drr_pkg::ST_IDLE) begin
        hcnt   <= '0;
        wcnt   <= '0;
        second <= 1'b0;
        count  <= '0;
      end
      if (state == drr_pkg::ST_PREP) begin
        rem_x  <= fold_x;
        rem_y  <= fold_y;
        fold_k <= fold_k - 4'd1;
        wx     <= 8'(fold_x);
        wy     <= 7'(fold_y);
      end
      if (state == drr_pkg::ST_READ) rd_ok <= map_ok;
      if (wr_en && !clearing && count != 15'h7FFF) count <= count + 15'd1;
      if (state == drr_pkg::ST_SCAN) begin
        if (!step) begin
          second <= 1'b1;
        end else begin
          second <= 1'b0;
          if (wcnt == last) begin
            wcnt <= '0;
            hcnt <= hcnt + 7'd1;
            wx   <= 8'(rem_x);
            wy   <= (wy == 7'd0) ? eff_h - 7'd1 : wy - 7'd1;
          end else begin
            wcnt <= wcnt + 7'd1;
            wx   <= (wx == 8'd0) ? eff_w - 8'd1 : wx - 8'd1;
          end
        end
      end
    end
  end

endmodule

[dv/disc_ring_rasterizer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disc_ring_rasterizer_test: self-checking testbench for the disc rasterizer
// Drives cell reads, plots, discs, rings and two-color discs through the
// request stream. A local framebuffer model predicts every result. The
// screen size and blank code are varied across phases, and both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module disc_ring_rasterizer_test;

  typedef struct {
    logic [2:0]         kind;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic [5:0]         radius;
    logic [5:0]         thickness;
    logic [15:0]        char_code;
    logic [15:0]        fill_color;
    logic [15:0]        ring_color;
    logic               skip_blank;
    logic               wrap;
  } draw_req_t;

  typedef struct {
    logic [15:0] read_char;
    logic [15:0] read_attr;
    logic [14:0] cells_written;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = drr_pkg::CFG_WIDTH;
  logic [15:0] cfg_data = '0;

  logic [31:0]  screen_model [drr_pkg::Cells];
  logic [7:0]   width_reg;
  logic [6:0]   height_reg;
  logic [15:0]  blank_reg;
  draw_result_t pending_results [$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           quiet_cycles = 0;

  disc_ring_rasterizer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit map_cell(int x, int y, bit wrap, output int idx);
    int w;
    int h;
    w = (width_reg < 1) ? 1 : (width_reg > drr_pkg::MaxWidth) ? drr_pkg::MaxWidth : width_reg;
    h = (height_reg < 1) ? 1 :
        (height_reg > drr_pkg::MaxHeight) ? drr_pkg::MaxHeight : height_reg;
    if (wrap) begin
      x = ((x % w) + w) % w;
      y = ((y % h) + h) % h;
    end else if (x < 0 || x >= w || y < 0 || y >= h) begin
      return 0;
    end
    idx = w * y + x;
    return idx < drr_pkg::Cells;
  endfunction

  function automatic void plot_cell(int x, int y, draw_req_t rq, logic [15:0] attr,
                                    ref int count);
    int idx;
    if (rq.skip_blank && rq.char_code == blank_reg) return;
    if (!map_cell(x, y, rq.wrap, idx)) return;
    screen_model[idx] = {attr, rq.char_code};
    if (count < 32767) count++;
  endfunction

  function automatic draw_result_t rasterize(draw_req_t rq);
    draw_result_t res;
    int r;
    int t;
    int idx;
    int count;
    int outer;
    int inner;
    int dx;
    int dy;
    int d;
    bit in_disc;
    bit in_ring;
    res = '{default: '0};
    count = 0;
    r = rq.radius > drr_pkg::MaxRadius ? drr_pkg::MaxRadius : rq.radius;
    t = rq.thickness;
    if (rq.kind == drr_pkg::KIND_READ) begin
      if (map_cell(rq.x_pos, rq.y_pos, rq.wrap, idx)) begin
        res.read_char = screen_model[idx][15:0];
        res.read_attr = screen_model[idx][31:16];
      end
    end else if (rq.kind == drr_pkg::KIND_PLOT) begin
      plot_cell(rq.x_pos, rq.y_pos, rq, rq.fill_color, count);
    end else if (rq.kind == drr_pkg::KIND_DISC || rq.kind == drr_pkg::KIND_RING ||
                 rq.kind == drr_pkg::KIND_BOTH) begin
      outer = r * r;
      inner = (r - t) * (r - t);
      for (int h = 0; h < 2 * r; h++) begin
        for (int w = 0; w < 2 * r; w++) begin
          dx = r - w;
          dy = r - h;
          d = dx * dx + dy * dy;
          in_disc = d < outer;
          in_ring = in_disc && d > inner;
          if ((rq.kind != drr_pkg::KIND_RING && in_disc) ||
              (rq.kind == drr_pkg::KIND_RING && in_ring))
            plot_cell(rq.x_pos + r + dx - 1, rq.y_pos + r + dy - 1, rq, rq.fill_color,
                      count);
          if (rq.kind == drr_pkg::KIND_BOTH && in_ring)
            plot_cell(rq.x_pos + r + dx - 1, rq.y_pos + r + dy - 1, rq, rq.ring_color,
                      count);
        end
      end
    end
    res.cells_written = 15'(count);
    return res;
  endfunction

  task automatic send_request(draw_req_t rq);
    s_axis_tuser <= rq.kind;
    s_axis_tdata <= {10'b0, rq.wrap, rq.skip_blank, rq.ring_color, rq.fill_color,
                     rq.char_code, rq.thickness, rq.radius, rq.y_pos, rq.x_pos};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(rasterize(rq));
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drr_pkg::CFG_WIDTH:  width_reg = value[7:0];
      drr_pkg::CFG_HEIGHT: height_reg = value[6:0];
      drr_pkg::CFG_BLANK:  blank_reg = value;
      default: ;
    endcase
  endtask

  function automatic draw_req_t make_req(logic [2:0] kind, int x, int y, int r, int t,
                                         logic [15:0] ch, bit skip, bit wrap);
    draw_req_t rq;
    rq.kind = kind;
    rq.x_pos = 12'(x);
    rq.y_pos = 12'(y);
    rq.radius = 6'(r);
    rq.thickness = 6'(t);
    rq.char_code = ch;
    rq.fill_color = 16'($urandom);
    rq.ring_color = 16'($urandom);
    rq.skip_blank = skip;
    rq.wrap = wrap;
    return rq;
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t rq;
    int pick;
    int w;
    int h;
    w = width_reg == 0 ? 1 : width_reg;
    h = height_reg == 0 ? 1 : height_reg;
    pick = $urandom_range(99);
    rq = make_req(3'(pick < 3 ? $urandom_range(7, 5) : $urandom_range(4)), 0, 0, 0, 0,
                  16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
    if ($urandom_range(9) == 0) begin
      rq.x_pos = 12'($urandom);
      rq.y_pos = 12'($urandom);
    end else begin
      rq.x_pos = 12'($signed($urandom_range(w + 20)) - 10);
      rq.y_pos = 12'($signed($urandom_range(h + 20)) - 10);
    end
    rq.radius = 6'(($urandom_range(99) == 0) ? $urandom_range(63, 30) : $urandom_range(7));
    rq.thickness = 6'(($urandom_range(3) == 0) ? $urandom : $urandom_range(4));
    if ($urandom_range(4) == 0) rq.char_code = blank_reg;
    return rq;
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    draw_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_r.read_char) begin
          $display("%0t: read_char expected %h actual %h", $time, exp_r.read_char,
                   m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_r.read_attr) begin
          $display("%0t: read_attr expected %h actual %h", $time, exp_r.read_attr,
                   m_axis_tdata[31:16]);
          errors++;
        end
        if (m_axis_tdata[46:32] !== exp_r.cells_written) begin
          $display("%0t: cells_written expected %0d actual %0d", $time,
                   exp_r.cells_written, m_axis_tdata[46:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 200000) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_cell_access;
    send_request(make_req(drr_pkg::KIND_READ, 0, 0, 0, 0, 16'h0, 0, 0));
    send_request(make_req(drr_pkg::KIND_PLOT, 0, 0, 0, 0, 16'hFFFF, 0, 0));
    send_request(make_req(drr_pkg::KIND_PLOT, 79, 24, 0, 0, 16'h1234, 1, 0));
    send_request(make_req(drr_pkg::KIND_PLOT, -2048, 2047, 0, 0, 16'h5555, 0, 0));
    send_request(make_req(drr_pkg::KIND_PLOT, 2047, -2048, 0, 0, 16'hAAAA, 0, 1));
    send_request(make_req(drr_pkg::KIND_PLOT, 5, 5, 0, 0, 16'd32, 1, 0));
    send_request(make_req(drr_pkg::KIND_READ, 0, 0, 0, 0, 16'h0, 0, 0));
    send_request(make_req(drr_pkg::KIND_READ, -1, -1, 0, 0, 16'h0, 0, 1));
    send_request(make_req(drr_pkg::KIND_READ, -2048, 2047, 0, 0, 16'h0, 0, 0));
    send_request(make_req(drr_pkg::KIND_READ, 2047, -2048, 0, 0, 16'h0, 0, 1));
  endtask

  task automatic test_discs;
    send_request(make_req(drr_pkg::KIND_DISC, 10, 5, 0, 0, 16'h41, 0, 0));
    send_request(make_req(drr_pkg::KIND_DISC, 10, 5, 1, 0, 16'h42, 0, 0));
    send_request(make_req(drr_pkg::KIND_DISC, 70, 20, 6, 0, 16'h43, 0, 0));
    send_request(make_req(drr_pkg::KIND_RING, 20, 5, 5, 2, 16'h44, 0, 1));
    send_request(make_req(drr_pkg::KIND_RING, 20, 5, 5, 0, 16'h45, 0, 0));
    send_request(make_req(drr_pkg::KIND_RING, 20, 5, 4, 63, 16'h46, 0, 0));
    send_request(make_req(drr_pkg::KIND_BOTH, -3, -3, 7, 3, 16'h47, 0, 1));
    send_request(make_req(drr_pkg::KIND_BOTH, 30, 2, 4, 1, 16'd32, 1, 0));
    send_request(make_req(drr_pkg::KIND_BOTH, -40, -30, 63, 9, 16'h48, 0, 1));
    send_request(make_req(drr_pkg::KIND_READ, 33, 5, 0, 0, 16'h0, 0, 0));
  endtask

  task automatic test_unused_kinds;
    for (logic [3:0] k = 4'(drr_pkg::KIND_BOTH) + 4'd1; k < 4'd8; k++)
      send_request(make_req(k[2:0], 1, 1, 3, 1, 16'h49, 0, 0));
  endtask

  task automatic test_random_phase(int idle_pct, int stall, int w, int h, int blank,
                                   int count);
    drain();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    write_reg(drr_pkg::CFG_WIDTH, 16'(w));
    write_reg(drr_pkg::CFG_HEIGHT, 16'(h));
    write_reg(drr_pkg::CFG_BLANK, 16'(blank));
    for (int i = 0; i < count; i++) send_request(random_req());
  endtask

  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
    width_reg = 80;
    height_reg = 25;
    blank_reg = 32;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_cell_access();
    test_discs();
    test_unused_kinds();
    test_random_phase(0, 0, 128, 64, 16'hFFFF, 140);
    test_random_phase(64, 0, 1, 1, 0, 140);
    test_random_phase(0, 64, 0, 127, 16'h7, 140);
    test_random_phase(7, 7, 255, 0, 16'h8000, 60);
    test_random_phase(7, 7, 37, 13, 32, 75);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/drr_pkg.sv
rtl/drr_front.sv
rtl/drr_engine.sv
rtl/disc_ring_rasterizer.sv
dv/disc_ring_rasterizer_test.sv
